// File: rtl/etf_pkg.sv
package etf_pkg;

   localparam int ITER_WIDTH      = 9;
   localparam int PIX_WIDTH       = 8;
   localparam int CSR_INDEX_WIDTH = 2;

   // register indexes of the configuration port
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_JULIA_MODE = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MAX_ITER   = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_JULIA_C_RE = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_JULIA_C_IM = 2'd3;

   localparam logic [ITER_WIDTH-1:0] MAX_ITER_RESET = 9'd256;

   typedef struct packed {
      logic                  julia_mode;
      logic [ITER_WIDTH-1:0] max_iter;
   } etf_ctrl_type;

   typedef struct packed {
      logic                 idle;
      logic                 done;
      logic [PIX_WIDTH-1:0] pixel;
   } etf_status_type;

endpackage

// File: rtl/etf_req_if.sv
interface etf_req_if #(parameter int COORD_WIDTH = 32) ();
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] point_re;
   logic signed [COORD_WIDTH-1:0] point_im;

   modport source (output valid, output point_re, output point_im, input ready);
   modport sink (input valid, input point_re, input point_im, output ready);
endinterface

// File: rtl/etf_rsp_if.sv
interface etf_rsp_if
   import etf_pkg::*;
   ();
   logic                 valid;
   logic                 ready;
   logic [PIX_WIDTH-1:0] pixel_value;

   modport source (output valid, output pixel_value, input ready);
   modport sink (input valid, input pixel_value, output ready);
endinterface

// File: rtl/etf_mul.sv
module etf_mul #(
   parameter int COORD_WIDTH = 32
) (
   input  logic                            clock,
   input  logic signed [COORD_WIDTH-1:0]   op_a,
   input  logic signed [COORD_WIDTH-1:0]   op_b,
   output logic signed [2*COORD_WIDTH-1:0] prod_ff
);

   localparam int PW = 2 * COORD_WIDTH;

   logic signed [PW-1:0] prod_in;

   // full signed product, registered
   assign prod_in = PW'(op_a) * PW'(op_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

// File: rtl/etf_core.sv
module etf_core
   import etf_pkg::*;
#(
   parameter int COORD_WIDTH = 32,
   parameter int FRAC_BITS   = 28
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic signed [COORD_WIDTH-1:0] point_re,
   input  logic signed [COORD_WIDTH-1:0] point_im,
   input  etf_ctrl_type                  ctrl,
   input  logic signed [COORD_WIDTH-1:0] c_re,
   input  logic signed [COORD_WIDTH-1:0] c_im,
   input  logic                          out_free,
   output etf_status_type                status
);

   localparam int W  = COORD_WIDTH;
   localparam int F  = FRAC_BITS;
   localparam int PW = 2 * W;
   localparam int DW = 2 * W + 1;
   localparam int SW = 2 * W - F + 2;
   localparam int MW = (2 * W + 1 > 2 * F + 3) ? 2 * W + 1 : 2 * F + 3;

   localparam logic [MW-1:0]        LIMIT = MW'(1) << (2 * F + 2);
   localparam logic signed [W-1:0]  CMAX  = {1'b0, {(W - 1){1'b1}}};
   localparam logic signed [W-1:0]  CMIN  = {1'b1, {(W - 1){1'b0}}};

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SQRE  = 3'd1;
   localparam logic [2:0] S_SQIM  = 3'd2;
   localparam logic [2:0] S_CROSS = 3'd3;
   localparam logic [2:0] S_UPD   = 3'd4;
   localparam logic [2:0] S_DONE  = 3'd5;

   logic [2:0]                  state_ff, state_in;
   logic [ITER_WIDTH-1:0]       iter_ff, iter_in;
   logic signed [W-1:0]         zr_ff, zr_in, zi_ff, zi_in;
   logic signed [W-1:0]         cr_ff, cr_in, ci_ff, ci_in;
   logic signed [PW-1:0]        rr_ff, rr_in;
   logic signed [DW-1:0]        diff_ff, diff_in;
   logic signed [W-1:0]         op_a, op_b;
   logic signed [PW-1:0]        prod;
   logic [MW-1:0]               mag;
   logic signed [SW-1:0]        re_sum, im_sum;
   logic signed [W-1:0]         re_sat, im_sat;

   etf_mul #(.COORD_WIDTH(W)) u_mul (
      .clock   (clock),
      .op_a    (op_a),
      .op_b    (op_b),
      .prod_ff (prod)
   );

   // |z|^2 from the stored re^2 and the im^2 arriving now
   assign mag = MW'($unsigned(rr_ff)) + MW'($unsigned(prod));

   // floor shift, add constant, saturate
   assign re_sum = SW'($signed(diff_ff[DW-1:F])) + SW'(cr_ff);
   assign im_sum = SW'($signed(prod[PW-1:F-1])) + SW'(ci_ff);

   always_comb begin
      if (re_sum > SW'(CMAX)) begin
         re_sat = CMAX;
      end else if (re_sum < SW'(CMIN)) begin
         re_sat = CMIN;
      end else begin
         re_sat = re_sum[W-1:0];
      end
      if (im_sum > SW'(CMAX)) begin
         im_sat = CMAX;
      end else if (im_sum < SW'(CMIN)) begin
         im_sat = CMIN;
      end else begin
         im_sat = im_sum[W-1:0];
      end
   end

   always_comb begin
      state_in = state_ff;
      iter_in  = iter_ff;
      zr_in    = zr_ff;
      zi_in    = zi_ff;
      cr_in    = cr_ff;
      ci_in    = ci_ff;
      rr_in    = rr_ff;
      diff_in  = diff_ff;
      op_a     = zr_ff;
      op_b     = zr_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               iter_in  = '0;
               state_in = S_SQRE;
               if (ctrl.julia_mode) begin
                  zr_in = point_re;
                  zi_in = point_im;
                  cr_in = c_re;
                  ci_in = c_im;
               end else begin
                  zr_in = '0;
                  zi_in = '0;
                  cr_in = point_re;
                  ci_in = point_im;
               end
            end
         end
         S_SQRE: begin
            if (iter_ff >= ctrl.max_iter) begin
               state_in = S_DONE;
            end else begin
               state_in = S_SQIM;
            end
         end
         S_SQIM: begin
            op_a     = zi_ff;
            op_b     = zi_ff;
            rr_in    = prod;
            state_in = S_CROSS;
         end
         S_CROSS: begin
            op_a    = zr_ff;
            op_b    = zi_ff;
            diff_in = DW'(rr_ff) - DW'(prod);
            if (mag >= LIMIT) begin
               state_in = S_DONE;
            end else begin
               state_in = S_UPD;
            end
         end
         S_UPD: begin
            zr_in    = re_sat;
            zi_in    = im_sat;
            iter_in  = iter_ff + 1'b1;
            state_in = S_SQRE;
         end
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      iter_ff <= iter_in;
      zr_ff   <= zr_in;
      zi_ff   <= zi_in;
      cr_ff   <= cr_in;
      ci_ff   <= ci_in;
      rr_ff   <= rr_in;
      diff_ff <= diff_in;
   end

   assign status.idle  = (state_ff == S_IDLE);
   assign status.done  = (state_ff == S_DONE);
   assign status.pixel = PIX_WIDTH'(iter_ff - 1'b1);

   a_iter_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> (iter_ff <= ctrl.max_iter))
      else $error("iteration count beyond limit");

   a_start_seq: assert property (@(posedge clock) disable iff (reset)
      start |=> (state_ff == S_SQRE))
      else $error("item accepted without starting iteration");

   a_done_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && !out_free) |=> (state_ff == S_DONE))
      else $error("result dropped while output busy");

endmodule

// File: rtl/escape_time_fractal_pixel.sv
// each iteration runs on the single shared multiplier in the steps re^2, im^2, re*im, update;
// an item ends when the limit is reached or the point escapes. The next item is taken once the
// core is idle, even while the previous result still waits in the output reg
// reset: synchronous, active high; clears config to mandelbrot mode, limit 256, c = 0
module escape_time_fractal_pixel
   import etf_pkg::*;
#(
   parameter int COORD_WIDTH = 32,
   parameter int FRAC_BITS   = 28
) (
   input  logic                                     clock,
   input  logic                                     reset,
   etf_req_if.sink                                  req_chan,
   etf_rsp_if.source                                rsp_chan,
   input  logic                                     csr_we,
   input  logic [CSR_INDEX_WIDTH-1:0]               csr_index,
   input  logic [((COORD_WIDTH > ITER_WIDTH) ? COORD_WIDTH : ITER_WIDTH)-1:0] csr_data
);

   // configuration registers
   logic                          julia_ff, julia_in;
   logic [ITER_WIDTH-1:0]         max_ff, max_in;
   logic signed [COORD_WIDTH-1:0] cre_ff, cre_in;
   logic signed [COORD_WIDTH-1:0] cim_ff, cim_in;

   // output register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [PIX_WIDTH-1:0]  rsp_pixel_ff, rsp_pixel_in;

   etf_ctrl_type   ctrl;
   etf_status_type status;
   logic           start;
   logic           out_free;
   logic           load;

   // register writes, one index per register
   always_comb begin
      julia_in = julia_ff;
      max_in   = max_ff;
      cre_in   = cre_ff;
      cim_in   = cim_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_JULIA_MODE: julia_in = csr_data[0];
            CSR_MAX_ITER:   max_in   = csr_data[ITER_WIDTH-1:0];
            CSR_JULIA_C_RE: cre_in   = csr_data[COORD_WIDTH-1:0];
            CSR_JULIA_C_IM: cim_in   = csr_data[COORD_WIDTH-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         julia_ff <= 1'b0;
         max_ff   <= MAX_ITER_RESET;
         cre_ff   <= '0;
         cim_ff   <= '0;
      end else begin
         julia_ff <= julia_in;
         max_ff   <= max_in;
         cre_ff   <= cre_in;
         cim_ff   <= cim_in;
      end
   end

   assign ctrl.julia_mode = julia_ff;
   assign ctrl.max_iter   = max_ff;

   // input side: take an item whenever the core is idle
   assign req_chan.ready = status.idle;
   assign start          = req_chan.valid && status.idle;

   etf_core #(
      .COORD_WIDTH (COORD_WIDTH),
      .FRAC_BITS   (FRAC_BITS)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .point_re (req_chan.point_re),
      .point_im (req_chan.point_im),
      .ctrl     (ctrl),
      .c_re     (cre_ff),
      .c_im     (cim_ff),
      .out_free (out_free),
      .status   (status)
   );

   // output register is free when empty or being drained this cycle
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign load     = status.done && out_free;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_pixel_in = rsp_pixel_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_pixel_in = status.pixel;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_pixel_ff <= rsp_pixel_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.pixel_value = rsp_pixel_ff;

endmodule
